// ----- src/b64sc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_pkg: shared types and helpers for the base64 stream codec
// Payload structs, stream state, alphabet mapping in both directions.
// ----------------------------------------------------------------------------
package b64sc_pkg;

	// result group size and count width
	localparam int MaxRes  = 4;
	localparam int ResCntW = $clog2(MaxRes + 1);
	localparam int PtrW    = $clog2(MaxRes);

	// configuration port
	localparam int CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] RegDecodeMode = 1'b0;
	localparam logic [CfgIdxW-1:0] RegUrlSafe    = 1'b1;

	// special characters
	localparam logic [7:0] CharPad   = 8'h3D; // '='
	localparam logic [7:0] CharMinus = 8'h2D; // '-'
	localparam logic [7:0] CharUnder = 8'h5F; // '_'
	localparam logic [7:0] CharPlus  = 8'h2B; // '+'
	localparam logic [7:0] CharSlash = 8'h2F; // '/'

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
	} res_t;

	typedef res_t [MaxRes-1:0] res_grp_t;

	typedef struct packed {
		logic decode_mode;
		logic url_safe;
	} cfg_t;

	typedef struct packed {
		logic [15:0] pending_bytes;
		logic [1:0]  pending_count;
		logic [11:0] bit_acc;
		logic [2:0]  acc_bits;
		logic        padding_seen;
	} state_t;

	// one processed item: its results and how many of them are real
	typedef struct packed {
		res_grp_t           res;
		logic [ResCntW-1:0] count;
	} step_out_t;

	// six-bit value to alphabet character
	function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
		logic [7:0] ch;
		if (v < 6'd26) begin
			ch = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			ch = 8'd71 + {2'b00, v};
		end else if (v < 6'd62) begin
			ch = {2'b00, v} - 8'd4;
		end else if (v == 6'd62) begin
			ch = url ? CharMinus : CharPlus;
		end else begin
			ch = url ? CharUnder : CharSlash;
		end
		return ch;
	endfunction

	// alphabet character to six-bit value, bit 6 set for an unknown character
	function automatic logic [6:0] char_sextet(input logic [7:0] c, input logic url);
		logic [7:0] t;
		logic [6:0] v;
		t = 8'h00;
		if (c >= 8'h41 && c <= 8'h5A) begin
			t = c - 8'h41;
			v = t[6:0];
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			t = c - 8'd71;
			v = t[6:0];
		end else if (c >= 8'h30 && c <= 8'h39) begin
			t = c + 8'd4;
			v = t[6:0];
		end else if (c == CharPlus || (url && c == CharMinus)) begin
			v = 7'd62;
		end else if (c == CharSlash || (url && c == CharUnder)) begin
			v = 7'd63;
		end else begin
			v = 7'd64;
		end
		return v;
	endfunction

endpackage

// ----- src/b64sc_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_step: per-item codec logic
// From the current stream state and one item, forms up to four results and
// the next stream state, for both encode and decode.
// ----------------------------------------------------------------------------
module b64sc_step (
	input  b64sc_pkg::cfg_t      cfg,
	input  b64sc_pkg::state_t    st,
	input  b64sc_pkg::item_t     item,
	output b64sc_pkg::step_out_t so,
	output b64sc_pkg::state_t    st_nxt
);

	logic [7:0]  b0;
	logic [7:0]  b1;
	logic [7:0]  c;
	logic [15:0] pb;
	logic [1:0]  pc;
	logic [6:0]  v;
	logic [3:0]  bits;
	logic [3:0]  bits_rem;
	logic [11:0] acc12;
	logic [11:0] acc_sh;

	always_comb begin
		b0       = st.pending_bytes[15:8];
		b1       = st.pending_bytes[7:0];
		c        = item.in_byte;
		pb       = st.pending_bytes;
		pc       = st.pending_count;
		v        = b64sc_pkg::char_sextet(c, cfg.url_safe);
		bits     = {1'b0, st.acc_bits} + 4'd6;
		bits_rem = bits - 4'd8;
		acc12    = {st.bit_acc[5:0], v[5:0]};
		acc_sh   = acc12 >> bits_rem[2:0];
		so       = '0;
		st_nxt   = st;

		if (!cfg.decode_mode) begin
			// encode: full group of three goes out as four characters
			if (st.pending_count >= 2'd2) begin
				so.res[0] = '{b64sc_pkg::sextet_char(b0[7:2], cfg.url_safe), 1'b1, 1'b0};
				so.res[1] = '{b64sc_pkg::sextet_char({b0[1:0], b1[7:4]}, cfg.url_safe),
					1'b1, 1'b0};
				so.res[2] = '{b64sc_pkg::sextet_char({b1[3:0], c[7:6]}, cfg.url_safe),
					1'b1, 1'b0};
				so.res[3] = '{b64sc_pkg::sextet_char(c[5:0], cfg.url_safe), 1'b1,
					item.in_last};
				so.count  = 3'(b64sc_pkg::MaxRes);
				st_nxt.pending_count = 2'd0;
				st_nxt.pending_bytes = 16'h0000;
			end else begin
				// hold the byte
				if (st.pending_count == 2'd0) begin
					pb = {c, 8'h00};
					pc = 2'd1;
				end else begin
					pb = {b0, c};
					pc = 2'd2;
				end
				st_nxt.pending_bytes = pb;
				st_nxt.pending_count = pc;
				// message end flushes a partial group
				if (item.in_last) begin
					so.res[0] = '{b64sc_pkg::sextet_char(pb[15:10], cfg.url_safe), 1'b1, 1'b0};
					if (pc == 2'd1) begin
						so.res[1] = '{b64sc_pkg::sextet_char({pb[9:8], 4'b0000}, cfg.url_safe),
							1'b1, cfg.url_safe};
						if (!cfg.url_safe) begin
							so.res[2] = '{b64sc_pkg::CharPad, 1'b1, 1'b0};
							so.res[3] = '{b64sc_pkg::CharPad, 1'b1, 1'b1};
							so.count  = 3'd4;
						end else begin
							so.count = 3'd2;
						end
					end else begin
						so.res[1] = '{b64sc_pkg::sextet_char(pb[9:4], cfg.url_safe), 1'b1, 1'b0};
						so.res[2] = '{b64sc_pkg::sextet_char({pb[3:0], 2'b00}, cfg.url_safe),
							1'b1, cfg.url_safe};
						if (!cfg.url_safe) begin
							so.res[3] = '{b64sc_pkg::CharPad, 1'b1, 1'b1};
							so.count  = 3'd4;
						end else begin
							so.count = 3'd3;
						end
					end
					st_nxt = '0;
				end
			end
		end else begin
			// decode: take six bits per alphabet character until padding
			if (!st.padding_seen) begin
				if (c == b64sc_pkg::CharPad) begin
					st_nxt.padding_seen = 1'b1;
				end else if (!v[6]) begin
					st_nxt.bit_acc = acc12;
					if (bits >= 4'd8) begin
						so.res[0] = '{acc_sh[7:0], 1'b1, item.in_last};
						so.count  = 3'd1;
						st_nxt.acc_bits = bits_rem[2:0];
					end else begin
						st_nxt.acc_bits = bits[2:0];
					end
				end
			end
			// message end, with an empty marker if nothing went out
			if (item.in_last) begin
				if (so.count == 3'd0) begin
					so.res[0] = '{8'h00, 1'b0, 1'b1};
					so.count  = 3'd1;
				end
				st_nxt = '0;
			end
		end
	end

endmodule

// ----- src/b64sc_outbuf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_outbuf: result register group
// Holds the results of one item and hands them out one per transaction.
// ----------------------------------------------------------------------------
module b64sc_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  b64sc_pkg::step_out_t so,
	output logic                 free,
	output b64sc_pkg::res_t      res,
	output logic                 res_valid,
	input  logic                 res_ready
);

	b64sc_pkg::res_grp_t                grp_q;
	logic [b64sc_pkg::ResCntW-1:0]      rem_q;
	logic [b64sc_pkg::PtrW-1:0]         ptr_q;

	// output side
	assign res_valid = (rem_q != '0);
	assign res       = grp_q[ptr_q];
	assign free      = (rem_q == '0) || (rem_q == 3'd1 && res_ready);

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= so.res;
		end
	end

	// remaining count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			ptr_q <= '0;
		end else if (load) begin
			rem_q <= so.count;
			ptr_q <= '0;
		end else if (res_valid && res_ready) begin
			rem_q <= rem_q - 3'd1;
			ptr_q <= ptr_q + 2'd1;
		end
	end

endmodule

// ----- src/base64_stream_codec_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec_core: streaming base64 encoder / decoder
// Input channel item/item_valid/item_ready takes one byte per transaction,
// in_last marking the end of a message. Output channel res/res_valid/
// res_ready gives characters (encode) or bytes (decode), last result marked.
// cfg_we/cfg_index/cfg_data write decode_mode (0) and url_safe (1); a write
// clears the stream state. The user is to write only while the block is
// idle; the block itself does not enforce this. An accepted item waits in
// the input register until the result register group is free, then its
// results (zero to four) load that group, which presents the first of them.
// Results leave one per cycle while res_ready is high, and the next item
// loads with the last one. In encoding, the first two bytes of a group are
// only held (unless they end the message) and the third gives four results;
// in decoding each character gives at most one result. The input register
// takes a new item while the last result of the previous one is leaving.
// When the receiver stalls, results hold and the input side fills, then
// item_ready drops. Reset clears configuration, stream state and queues.
// ----------------------------------------------------------------------------
module base64_stream_codec_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  b64sc_pkg::item_t                    item,
	input  logic                                item_valid,
	output logic                                item_ready,
	output b64sc_pkg::res_t                     res,
	output logic                                res_valid,
	input  logic                                res_ready,
	input  logic                                cfg_we,
	input  logic [b64sc_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic                                cfg_data
);

	b64sc_pkg::cfg_t      cfg_q;
	b64sc_pkg::state_t    st_q;
	b64sc_pkg::state_t    st_nxt;
	b64sc_pkg::item_t     item_s1;
	logic                 vld_s1;
	b64sc_pkg::step_out_t so;
	logic                 buf_free;
	logic                 advance;

	// input register moves on when the result group frees up
	assign advance    = vld_s1 && buf_free;
	assign item_ready = !vld_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				b64sc_pkg::RegDecodeMode: cfg_q.decode_mode <= cfg_data;
				b64sc_pkg::RegUrlSafe:    cfg_q.url_safe    <= cfg_data;
				default:                  cfg_q             <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_ready) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (cfg_we) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	b64sc_step u_step (
		.cfg    (cfg_q),
		.st     (st_q),
		.item   (item_s1),
		.so     (so),
		.st_nxt (st_nxt)
	);

	b64sc_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.so        (so),
		.free      (buf_free),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	// held item stays put while the result group is busy
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !buf_free) |=> (vld_s1 && $stable(item_s1)))
		else $error("input register lost an item while results were busy");

	// never more than two bytes pending
	a_pend_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.pending_count != 2'd3)
		else $error("pending byte count out of range");

	// decode bit count stays even
	a_acc_even: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.acc_bits[0])
		else $error("odd accumulated bit count");

	// message end leaves a clean stream state
	a_last_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.in_last) |=> (st_q == '0))
		else $error("stream state not cleared at message end");

	// a loaded item with results shows them next cycle
	a_load_show: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && so.count != '0) |=> res_valid)
		else $error("loaded results not presented");

endmodule
